FILE: hdl/stec_pkg.sv
// Shared types and constants of the space-time exponential covariance core.
// Holds the register file layout, the sideband that travels with each item and fixed-point
// constants. Depends on nothing.
`default_nettype none

package stec_pkg;

  typedef enum logic [2:0] {
    REG_DECAY       = 3'd0,
    REG_LAT_WEIGHT  = 3'd1,
    REG_TIME_WEIGHT = 3'd2,
    REG_DRIFT_LAT   = 3'd3,
    REG_DRIFT_LON   = 3'd4,
    REG_NUGGET      = 3'd5,
    REG_SILL        = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic        [31:0] decay_rate;
    logic        [31:0] latitude_weight;
    logic        [31:0] time_weight;
    logic signed [31:0] drift_latitude;
    logic signed [31:0] drift_longitude;
    logic        [31:0] nugget_variance;
    logic        [31:0] sill_variance;
  } cfg_t;

  // Control that travels alongside every item through all stages.
  typedef struct packed {
    logic valid;
    logic pad;
    logic pad_one;
    logic diag;
  } side_t;

  localparam int unsigned SQRT_STEPS   = 40;
  localparam int unsigned SERIES_TERMS = 12;

  localparam logic [31:0] Q16_ONE     = 32'h0001_0000;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [21:0] EXP_CUTOFF  = 22'd2621440;
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [47:0] JITTER_Q32  = 48'd4295;
  localparam logic [47:0] OUT_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SQ_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: hdl/space_time_exponential_covariance_core.sv
// Top level of the space-time exponential covariance core: register file, pipeline
// assembly and final scaling. Uses stec_pkg, stec_dist, stec_sqrt and stec_exp.
//
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+--------------------------------
// command   | in        | start, busy (always low)     | two points, padding, same_point
// result    | out       | result_valid_o strobe        | covariance_value_o
// config    | in        | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item is taken in every clock cycle; busy is never raised, so start alone admits an item.
// Each result appears on the result ports for a single cycle; the 40 single-bit root stages
// and the 24 stages of the exponential series make up most of the pipeline.
// The receiver cannot stall, so nothing is ever held back.
// Reset clears the valid bits of every stage and restores the register defaults.
// Configuration writes are always taken; they must only arrive while no item is in flight.
`default_nettype none

module space_time_exponential_covariance_core import stec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_latitude_i,
  input  logic signed [31:0] first_longitude_i,
  input  logic signed [31:0] first_time_i,
  input  logic signed [31:0] second_latitude_i,
  input  logic signed [31:0] second_longitude_i,
  input  logic signed [31:0] second_time_i,
  input  logic               first_padding_i,
  input  logic               second_padding_i,
  input  logic               same_point_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [47:0]        covariance_value_o
);

  localparam int LATENCY = 78;

  cfg_t        cfg_q;
  side_t       side_in;
  side_t       side_dist, side_sqrt, side_exp, side_f2_q;
  logic [63:0] sq_dist;
  logic [39:0] root;
  logic [32:0] e_val;
  logic [64:0] prod_q;
  logic [49:0] total_d;
  logic [47:0] value_d, value_q;
  logic        valid_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Register file; writes to an index beyond the list fall through and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_rate      <= Q16_ONE;
      cfg_q.latitude_weight <= Q16_ONE;
      cfg_q.time_weight     <= Q16_ONE;
      cfg_q.drift_latitude  <= '0;
      cfg_q.drift_longitude <= '0;
      cfg_q.nugget_variance <= '0;
      cfg_q.sill_variance   <= Q16_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DECAY:       cfg_q.decay_rate      <= cfg_data_i;
        REG_LAT_WEIGHT:  cfg_q.latitude_weight <= cfg_data_i;
        REG_TIME_WEIGHT: cfg_q.time_weight     <= cfg_data_i;
        REG_DRIFT_LAT:   cfg_q.drift_latitude  <= cfg_data_i;
        REG_DRIFT_LON:   cfg_q.drift_longitude <= cfg_data_i;
        REG_NUGGET:      cfg_q.nugget_variance <= cfg_data_i;
        REG_SILL:        cfg_q.sill_variance   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Padding is resolved on entry; the padded item still flows down the pipeline so that
  // results leave in order, and its arithmetic is simply overridden at the end.
  always_comb begin
    side_in.valid   = start && !busy;
    side_in.pad     = first_padding_i || second_padding_i;
    side_in.pad_one = same_point_i && first_padding_i;
    side_in.diag    = same_point_i;
  end

  stec_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .side_i    (side_in),
    .lat1_i    (first_latitude_i),
    .lon1_i    (first_longitude_i),
    .t1_i      (first_time_i),
    .lat2_i    (second_latitude_i),
    .lon2_i    (second_longitude_i),
    .t2_i      (second_time_i),
    .side_o    (side_dist),
    .sq_dist_o (sq_dist)
  );

  stec_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_dist),
    .s_i    (sq_dist),
    .side_o (side_sqrt),
    .root_o (root)
  );

  stec_exp u_exp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decay_rate_i (cfg_q.decay_rate),
    .side_i       (side_sqrt),
    .d_i          (root),
    .side_o       (side_exp),
    .e_o          (e_val)
  );

  // Scale by the sill, then add the nugget and jitter on the diagonal and saturate.
  always_comb begin
    total_d = 50'(prod_q[64:16]);
    if (side_f2_q.diag) begin
      total_d = total_d + 50'({cfg_q.nugget_variance, 16'd0}) + 50'(JITTER_Q32);
    end
    if (side_f2_q.pad) begin
      value_d = side_f2_q.pad_one ? 48'(ONE_Q32) : '0;
    end else if (total_d[49:48] != '0) begin
      value_d = OUT_MAX;
    end else begin
      value_d = total_d[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_f2_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      side_f2_q <= side_exp;
      valid_q   <= side_f2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= 65'(cfg_q.sill_variance) * 65'(e_val);
    value_q <= value_d;
  end

  assign result_valid_o     = valid_q;
  assign covariance_value_o = value_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(start && (first_padding_i || second_padding_i) &&
                             !(same_point_i && first_padding_i), LATENCY))
    |-> (covariance_value_o == '0))
    else $error("padded off-diagonal entry is not zero");

  a_pad_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(start && first_padding_i && same_point_i, LATENCY))
    |-> (covariance_value_o == 48'(ONE_Q32)))
    else $error("padded diagonal entry is not one");

endmodule

`default_nettype wire

FILE: hdl/stec_dist.sv
// Advection and weighted squared distance: seven register stages.
// Uses stec_pkg for the register file and the sideband type.
`default_nettype none

module stec_dist import stec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  side_t              side_i,
  input  logic signed [31:0] lat1_i,
  input  logic signed [31:0] lon1_i,
  input  logic signed [31:0] t1_i,
  input  logic signed [31:0] lat2_i,
  input  logic signed [31:0] lon2_i,
  input  logic signed [31:0] t2_i,
  output side_t              side_o,
  output logic [63:0]        sq_dist_o
);

  side_t side_q [7];

  // Stage 1: drift times time.
  logic signed [63:0] pl1_q, pl2_q, pn1_q, pn2_q;
  logic signed [31:0] la1_q, lo1_q, la2_q, lo2_q;
  logic signed [32:0] dt_q;
  // Stage 2: magnitudes of the differences.
  logic signed [49:0] dlat_d, dlon_d;
  logic        [49:0] mlat_d, mlon_d, mlat_q, mlon_q;
  logic        [32:0] mt_d, mt_q;
  // Stage 3: partial products of the squares.
  logic [49:0] lat_ll_q, lat_lh_q, lat_hh_q, lon_ll_q, lon_lh_q, lon_hh_q;
  logic [65:0] tsq_q;
  // Stage 4: squares in Q.16.
  logic [63:0] sq_lat_q, sq_lon_q;
  logic [49:0] sq_t_q;
  // Stage 5: weighting partial products.
  logic [63:0] lw_lo_q, lw_hi_q, tw_lo_q;
  logic [49:0] tw_hi_q;
  logic [63:0] sq_lon5_q;
  // Stage 6: weighted terms.
  logic [95:0] lat_full_d;
  logic [81:0] t_full_d;
  logic [63:0] s_lat_q, s_t_q, sq_lon6_q;
  // Stage 7: saturated sum.
  logic [65:0] sum_d;
  logic [63:0] sq_dist_q;

  function automatic logic [63:0] square_q16(input logic [49:0] ll, input logic [49:0] lh,
                                             input logic [49:0] hh);
    logic [99:0] full;
    full = {hh, 50'd0} + {24'd0, lh, 26'd0} + {50'd0, ll};
    return (full[99:80] != '0) ? SQ_MAX : full[79:16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) side_q[i] <= '0;
    end else begin
      side_q[0] <= side_i;
      for (int i = 1; i < 7; i++) side_q[i] <= side_q[i-1];
    end
  end

  always_comb begin
    dlat_d = (50'(la1_q) - 50'(pl1_q >>> 16)) - (50'(la2_q) - 50'(pl2_q >>> 16));
    dlon_d = (50'(lo1_q) - 50'(pn1_q >>> 16)) - (50'(lo2_q) - 50'(pn2_q >>> 16));
    mlat_d = dlat_d[49] ? 50'(-dlat_d) : 50'(dlat_d);
    mlon_d = dlon_d[49] ? 50'(-dlon_d) : 50'(dlon_d);
    mt_d   = dt_q[32] ? 33'(-dt_q) : 33'(dt_q);
    lat_full_d = {32'd0, lw_lo_q} + {lw_hi_q, 32'd0};
    t_full_d   = {18'd0, tw_lo_q} + {tw_hi_q, 32'd0};
    sum_d = 66'(s_lat_q) + 66'(sq_lon6_q) + 66'(s_t_q);
  end

  always_ff @(posedge clk_i) begin
    pl1_q <= cfg_i.drift_latitude * t1_i;
    pl2_q <= cfg_i.drift_latitude * t2_i;
    pn1_q <= cfg_i.drift_longitude * t1_i;
    pn2_q <= cfg_i.drift_longitude * t2_i;
    la1_q <= lat1_i;
    lo1_q <= lon1_i;
    la2_q <= lat2_i;
    lo2_q <= lon2_i;
    dt_q  <= 33'(t1_i) - 33'(t2_i);

    mlat_q <= mlat_d;
    mlon_q <= mlon_d;
    mt_q   <= mt_d;

    lat_ll_q <= 50'(mlat_q[24:0]) * 50'(mlat_q[24:0]);
    lat_lh_q <= 50'(mlat_q[24:0]) * 50'(mlat_q[49:25]);
    lat_hh_q <= 50'(mlat_q[49:25]) * 50'(mlat_q[49:25]);
    lon_ll_q <= 50'(mlon_q[24:0]) * 50'(mlon_q[24:0]);
    lon_lh_q <= 50'(mlon_q[24:0]) * 50'(mlon_q[49:25]);
    lon_hh_q <= 50'(mlon_q[49:25]) * 50'(mlon_q[49:25]);
    tsq_q    <= 66'(mt_q) * 66'(mt_q);

    sq_lat_q <= square_q16(lat_ll_q, lat_lh_q, lat_hh_q);
    sq_lon_q <= square_q16(lon_ll_q, lon_lh_q, lon_hh_q);
    sq_t_q   <= tsq_q[65:16];

    lw_lo_q   <= 64'(cfg_i.latitude_weight) * 64'(sq_lat_q[31:0]);
    lw_hi_q   <= 64'(cfg_i.latitude_weight) * 64'(sq_lat_q[63:32]);
    tw_lo_q   <= 64'(cfg_i.time_weight) * 64'(sq_t_q[31:0]);
    tw_hi_q   <= 50'(cfg_i.time_weight) * 50'(sq_t_q[49:32]);
    sq_lon5_q <= sq_lon_q;

    s_lat_q   <= (lat_full_d[95:80] != '0) ? SQ_MAX : lat_full_d[79:16];
    s_t_q     <= (t_full_d[81:80] != '0) ? SQ_MAX : t_full_d[79:16];
    sq_lon6_q <= sq_lon5_q;

    sq_dist_q <= (sum_d[65:64] != '0) ? SQ_MAX : sum_d[63:0];
  end

  assign side_o    = side_q[6];
  assign sq_dist_o = sq_dist_q;

endmodule

`default_nettype wire

FILE: hdl/stec_sqrt.sv
// Digit-by-digit square root, one result bit per register stage.
// Uses stec_pkg for the sideband type and the step count.
`default_nettype none

module stec_sqrt import stec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  side_t       side_i,
  input  logic [63:0] s_i,
  output side_t       side_o,
  output logic [39:0] root_o
);

  side_t       side_q [SQRT_STEPS];
  logic [63:0] s_q    [SQRT_STEPS];
  logic [39:0] root_q [SQRT_STEPS];
  logic [40:0] rem_q  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int I = SQRT_STEPS - 1 - j;
    side_t       side_in;
    logic [63:0] s_in;
    logic [39:0] root_in;
    logic [40:0] rem_in;
    logic [1:0]  pair;
    logic [42:0] rem_sh, trial;

    if (j == 0) begin : g_first
      assign side_in = side_i;
      assign s_in    = s_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign side_in = side_q[j-1];
      assign s_in    = s_q[j-1];
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
    end

    // The radicand is scaled by 2^16, so its lowest eight digit pairs are zero.
    if (2 * I >= 16) begin : g_pair
      assign pair = s_in[2*I-15:2*I-16];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in, pair};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
      end else begin
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      s_q[j] <= s_in;
      if (rem_sh >= trial) begin
        rem_q[j]  <= 41'(rem_sh - trial);
        root_q[j] <= {root_in[38:0], 1'b1};
      end else begin
        rem_q[j]  <= rem_sh[40:0];
        root_q[j] <= {root_in[38:0], 1'b0};
      end
    end
  end

  assign side_o = side_q[SQRT_STEPS-1];
  assign root_o = root_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: hdl/stec_exp.sv
// Negative exponential exp(-decay*d) in Q.32: range reduction by powers of two and a
// twelve-term Taylor series, two register stages per term. Uses stec_pkg.
`default_nettype none

module stec_exp import stec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] decay_rate_i,
  input  side_t       side_i,
  input  logic [39:0] d_i,
  output side_t       side_o,
  output logic [32:0] e_o
);

  typedef struct packed {
    side_t              side;
    logic               zero;
    logic [6:0]         n;
    logic [31:0]        g;
    logic signed [35:0] sum;
    logic [32:0]        t;
  } ser_t;

  side_t side1_q, side2_q, side3_q, side4_q, side_f_q;
  logic [63:0] pa_q;
  logic [39:0] pb_q;
  logic [71:0] px_d;
  logic [55:0] x_d;
  logic [21:0] x2_q;
  logic        zero2_q, zero3_q, zero4_q;
  logic [52:0] y3_q;
  logic [63:0] gp4_q;
  logic [6:0]  n4_q;
  ser_t        init_d;
  ser_t        a_q [SERIES_TERMS];
  ser_t        b_q [SERIES_TERMS];
  logic [32:0] e_q;
  ser_t        last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q  <= '0;
      side2_q  <= '0;
      side3_q  <= '0;
      side4_q  <= '0;
      side_f_q <= '0;
    end else begin
      side1_q  <= side_i;
      side2_q  <= side1_q;
      side3_q  <= side2_q;
      side4_q  <= side3_q;
      side_f_q <= b_q[SERIES_TERMS-1].side;
    end
  end

  always_comb begin
    px_d = 72'(pa_q) + {pb_q, 32'd0};
    x_d  = px_d[71:16];
    init_d      = '0;
    init_d.side = side4_q;
    init_d.zero = zero4_q;
    init_d.n    = n4_q;
    init_d.g    = gp4_q[63:32];
    init_d.sum  = 36'(ONE_Q32);
    init_d.t    = ONE_Q32;
    last_d      = b_q[SERIES_TERMS-1];
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= 64'(decay_rate_i) * 64'(d_i[31:0]);
    pb_q    <= 40'(decay_rate_i) * 40'(d_i[39:32]);
    zero2_q <= (x_d[55:22] != '0) || (x_d[21:0] >= EXP_CUTOFF);
    x2_q    <= x_d[21:0];
    y3_q    <= 53'(x2_q) * 53'(LOG2E_Q30);
    zero3_q <= zero2_q;
    gp4_q   <= 64'(y3_q[45:14]) * 64'(LN2_Q32);
    n4_q    <= y3_q[52:46];
    zero4_q <= zero3_q;
    if (last_d.zero || last_d.sum < 0) begin
      e_q <= '0;
    end else begin
      e_q <= last_d.sum[32:0] >> last_d.n;
    end
  end

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    // floor(p / K) as a multiply by a rounded-up reciprocal, exact for 33-bit p.
    localparam int          L  = $clog2(k);
    localparam logic [63:0] MF = (64'd1 << (33 + L)) / 64'(k) + 64'd1;
    localparam logic [34:0] M  = MF[34:0];
    ser_t        in_d, a_d, b_d;
    logic [64:0] tg;
    logic [67:0] qm;

    if (k == 1) begin : g_first
      assign in_d = init_d;
    end else begin : g_next
      assign in_d = b_q[k-2];
    end

    always_comb begin
      tg    = 65'(in_d.t) * 65'(in_d.g);
      a_d   = in_d;
      a_d.t = tg[64:32];
      qm    = 68'(a_q[k-1].t) * 68'(M);
      b_d   = a_q[k-1];
      b_d.t = 33'(qm >> (33 + L));
      if (k % 2 == 1) begin
        b_d.sum = a_q[k-1].sum - 36'(b_d.t);
      end else begin
        b_d.sum = a_q[k-1].sum + 36'(b_d.t);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_q[k-1] <= '0;
        b_q[k-1] <= '0;
      end else begin
        a_q[k-1] <= a_d;
        b_q[k-1] <= b_d;
      end
    end
  end

  assign side_o = side_f_q;
  assign e_o    = e_q;

  a_e_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_f_q.valid |-> (e_q <= ONE_Q32))
    else $error("exponential result above one");

endmodule

`default_nettype wire
